// ----- hdl/guillotine_rect_packer_core_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the guillotine rectangle packer
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef GUILLOTINE_RECT_PACKER_CORE_ASSERT_SVH
`define GUILLOTINE_RECT_PACKER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define GRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define GRP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define GRP_ASSERT(lbl, prop, msg)
`define GRP_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

// ----- hdl/grp_pkg.sv -----
// ---------------------------------------------------------------------------
// Guillotine rectangle packer package
// Shared widths, codes, word types and controller/datapath interfaces.
// ---------------------------------------------------------------------------
package grp_pkg;

  localparam int MAX_FREE = 256;
  localparam int MAX_SIDE = 4096;
  localparam int IDX_W    = $clog2(MAX_FREE);
  localparam int CNT_W    = IDX_W + 1;
  localparam int COORD_W  = 13;
  localparam int POS_W    = 12;
  localparam int PAD_W    = 8;

  localparam logic [1:0] CFG_ATLAS_W = 2'd0;
  localparam logic [1:0] CFG_ATLAS_H = 2'd1;
  localparam logic [1:0] CFG_PADDING = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_NOFIT = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic               func;
    logic [COORD_W-1:0] rect_width;
    logic [COORD_W-1:0] rect_height;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
  } out_word_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
  } frect_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_SPLIT,
    ST_DECIDE,
    ST_SHDN,
    ST_SHUP,
    ST_WR0,
    ST_WR1,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       take;
    logic       load_root;
    logic       scan_start;
    logic       scan_step;
    logic       capture;
    logic       split;
    logic       shdn_start;
    logic       shup_start;
    logic       shift_step;
    logic       wr_l0;
    logic       wr_l1;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       res_set;
    logic       res_place;
    logic [1:0] res_code;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic       is_restart;
    logic       hit;
    logic       miss;
    logic       full;
    logic       shift_done;
    logic       out_busy;
    logic [1:0] n_left;
  } stat_t;

endpackage

// ----- hdl/grp_dpath.sv -----
// ---------------------------------------------------------------------------
// Packer datapath
// Free list memory, scan and shift pointers, split arithmetic, result word.
// ---------------------------------------------------------------------------
`include "guillotine_rect_packer_core_assert.svh"

module grp_dpath (
  input  logic                       clk,
  input  logic                       rst,
  input  grp_pkg::cmd_t              cmd,
  output grp_pkg::stat_t             stat,
  input  grp_pkg::in_word_t          in_word,
  input  logic                       out_ready,
  output logic                       out_valid,
  output grp_pkg::out_word_t         out_word,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [grp_pkg::COORD_W-1:0] cfg_wdata
);

  localparam int IW = grp_pkg::IDX_W;
  localparam int CW = grp_pkg::CNT_W;
  localparam int DW = grp_pkg::COORD_W;

  logic [DW-1:0] cfg_aw, cfg_ah;
  logic [grp_pkg::PAD_W-1:0] cfg_pad;

  grp_pkg::frect_t mem [grp_pkg::MAX_FREE];
  grp_pkg::frect_t rd_data;
  logic [IW-1:0]   rd_addr;
  logic            mem_we;
  logic [IW-1:0]   mem_wa;
  grp_pkg::frect_t mem_wd;

  logic          item_func;
  logic [DW-1:0] item_w, item_h;
  logic [CW-1:0] count;

  logic [CW-1:0] idx;
  logic          chk_vld, armed;
  logic [IW-1:0] chk_idx;
  logic          fits;

  logic [IW-1:0]   sel;
  grp_pkg::frect_t rect, l0, l1, l0_next, l1_next;
  logic [1:0]      n_left, n_left_next;

  logic [CW-1:0] sp;
  logic          dir_up, wv, issue;
  logic [IW-1:0] wa;

  grp_pkg::out_word_t res;
  grp_pkg::frect_t    root;
  logic               root_ok;

  // Split arithmetic on the captured rectangle.
  logic [DW-1:0] dw, dh;
  logic [DW:0]   iwp, ihp;
  logic          below_ok, right_ok, wide;
  grp_pkg::frect_t below, right;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_aw  <= DW'(2048);
      cfg_ah  <= DW'(2048);
      cfg_pad <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        grp_pkg::CFG_ATLAS_W: cfg_aw  <= cfg_wdata;
        grp_pkg::CFG_ATLAS_H: cfg_ah  <= cfg_wdata;
        grp_pkg::CFG_PADDING: cfg_pad <= cfg_wdata[grp_pkg::PAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    root.x  = '0;
    root.y  = '0;
    root.w  = (cfg_aw > DW'(grp_pkg::MAX_SIDE)) ? DW'(grp_pkg::MAX_SIDE) : cfg_aw;
    root.h  = (cfg_ah > DW'(grp_pkg::MAX_SIDE)) ? DW'(grp_pkg::MAX_SIDE) : cfg_ah;
    root_ok = (cfg_aw != '0) && (cfg_ah != '0);
  end

  assign rd_addr = cmd.scan_step ? idx[IW-1:0] : sp[IW-1:0];

  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = rd_data;
    if (cmd.load_root) begin
      mem_we = root_ok;
      mem_wd = root;
    end else if (wv) begin
      mem_we = 1'b1;
      mem_wa = wa;
    end else if (cmd.wr_l0) begin
      mem_we = 1'b1;
      mem_wa = sel;
      mem_wd = l0;
    end else if (cmd.wr_l1) begin
      mem_we = 1'b1;
      mem_wa = sel + IW'(1);
      mem_wd = l1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_func <= in_word.func;
      item_w    <= in_word.rect_width;
      item_h    <= in_word.rect_height;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load_root) begin
      count <= root_ok ? CW'(1) : '0;
    end else if (cmd.cnt_inc) begin
      count <= count + CW'(1);
    end else if (cmd.cnt_dec) begin
      count <= count - CW'(1);
    end
  end

  // The scan reads one entry per cycle; the fit test sees each entry in the cycle after its read.
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_vld <= 1'b0;
      armed   <= 1'b0;
      idx     <= '0;
    end else if (cmd.scan_start) begin
      chk_vld <= 1'b0;
      armed   <= 1'b0;
      idx     <= '0;
    end else if (cmd.scan_step) begin
      chk_vld <= idx < count;
      armed   <= 1'b1;
      idx     <= idx + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      chk_idx <= idx[IW-1:0];
    end
  end

  assign fits = (item_w != '0) && (item_h != '0) &&
                (item_w <= rd_data.w) && (item_h <= rd_data.h);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sel  <= chk_idx;
      rect <= rd_data;
    end
  end

  always_comb begin
    dw       = rect.w - item_w;
    dh       = rect.h - item_h;
    iwp      = {1'b0, item_w} + (DW+1)'(cfg_pad);
    ihp      = {1'b0, item_h} + (DW+1)'(cfg_pad);
    below_ok = {1'b0, rect.h} > ihp;
    right_ok = {1'b0, rect.w} > iwp;
    wide     = dw > dh;
    below.x  = rect.x;
    below.y  = rect.y + ihp[DW-1:0];
    below.w  = wide ? item_w : rect.w;
    below.h  = rect.h - ihp[DW-1:0];
    right.x  = rect.x + iwp[DW-1:0];
    right.y  = rect.y;
    right.w  = rect.w - iwp[DW-1:0];
    right.h  = wide ? rect.h : item_h;
    if (wide) begin
      l0_next     = below_ok ? below : right;
      l1_next     = right;
      n_left_next = {1'b0, below_ok} + {1'b0, right_ok};
    end else begin
      l0_next     = right_ok ? right : below;
      l1_next     = below;
      n_left_next = {1'b0, below_ok} + {1'b0, right_ok};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.split) begin
      l0     <= l0_next;
      l1     <= l1_next;
      n_left <= n_left_next;
    end
  end

  // Shift engine: read one entry, write it one slot over on the next cycle.
  assign issue = dir_up ? (sp > {1'b0, sel}) : (sp < count);

  always_ff @(posedge clk) begin
    if (rst) begin
      wv <= 1'b0;
    end else if (cmd.shdn_start || cmd.shup_start) begin
      wv <= 1'b0;
    end else if (cmd.shift_step) begin
      wv <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shdn_start) begin
      sp     <= {1'b0, sel} + CW'(1);
      dir_up <= 1'b0;
    end else if (cmd.shup_start) begin
      sp     <= count - CW'(1);
      dir_up <= 1'b1;
    end else if (cmd.shift_step && issue) begin
      wa <= dir_up ? sp[IW-1:0] + IW'(1) : sp[IW-1:0] - IW'(1);
      sp <= dir_up ? sp - CW'(1) : sp + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res.status <= cmd.res_code;
      res.pos_x  <= cmd.res_place ? rect.x[grp_pkg::POS_W-1:0] : '0;
      res.pos_y  <= cmd.res_place ? rect.y[grp_pkg::POS_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word <= res;
    end
  end

  always_comb begin
    stat.is_restart = item_func;
    stat.hit        = chk_vld && fits;
    stat.miss       = armed && !chk_vld;
    stat.full       = count == CW'(grp_pkg::MAX_FREE);
    stat.shift_done = !issue && !wv;
    stat.out_busy   = out_valid && !out_ready;
    stat.n_left     = n_left;
  end

  `GRP_ASSERT(a_count_max, count <= CW'(grp_pkg::MAX_FREE), "free count above capacity")
  `GRP_ASSERT_IMP(a_hit_in_list, cmd.capture, {1'b0, chk_idx} < count, "scan hit past list end")
  `GRP_ASSERT_IMP(a_shift_wa, wv, {1'b0, wa} <= count, "shift writes past list end")

endmodule

// ----- hdl/grp_ctrl.sv -----
// ---------------------------------------------------------------------------
// Packer controller
// Sequences restart, first-fit scan, split, list shift and result delivery.
// ---------------------------------------------------------------------------
`include "guillotine_rect_packer_core_assert.svh"

module grp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  grp_pkg::stat_t stat,
  output grp_pkg::cmd_t  cmd
);

  grp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= grp_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      grp_pkg::ST_INIT: begin
        cmd.load_root = 1'b1;
        state_next    = grp_pkg::ST_IDLE;
      end
      grp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = grp_pkg::ST_DISPATCH;
        end
      end
      grp_pkg::ST_DISPATCH: begin
        if (stat.is_restart) begin
          cmd.load_root = 1'b1;
          cmd.res_set   = 1'b1;
          cmd.res_code  = grp_pkg::STAT_OK;
          state_next    = grp_pkg::ST_DONE;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = grp_pkg::ST_SCAN;
        end
      end
      grp_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.hit) begin
          cmd.capture = 1'b1;
          state_next  = grp_pkg::ST_SPLIT;
        end else if (stat.miss) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = grp_pkg::STAT_NOFIT;
          state_next   = grp_pkg::ST_DONE;
        end
      end
      grp_pkg::ST_SPLIT: begin
        cmd.split  = 1'b1;
        state_next = grp_pkg::ST_DECIDE;
      end
      grp_pkg::ST_DECIDE: begin
        cmd.res_set = 1'b1;
        if (stat.n_left == 2'd2 && stat.full) begin
          cmd.res_code = grp_pkg::STAT_FULL;
          state_next   = grp_pkg::ST_DONE;
        end else begin
          cmd.res_code  = grp_pkg::STAT_OK;
          cmd.res_place = 1'b1;
          case (stat.n_left)
            2'd0: begin
              cmd.shdn_start = 1'b1;
              state_next     = grp_pkg::ST_SHDN;
            end
            2'd1: state_next = grp_pkg::ST_WR0;
            default: begin
              cmd.shup_start = 1'b1;
              state_next     = grp_pkg::ST_SHUP;
            end
          endcase
        end
      end
      grp_pkg::ST_SHDN: begin
        cmd.shift_step = 1'b1;
        if (stat.shift_done) begin
          cmd.cnt_dec = 1'b1;
          state_next  = grp_pkg::ST_DONE;
        end
      end
      grp_pkg::ST_SHUP: begin
        cmd.shift_step = 1'b1;
        if (stat.shift_done) begin
          state_next = grp_pkg::ST_WR0;
        end
      end
      grp_pkg::ST_WR0: begin
        cmd.wr_l0  = 1'b1;
        state_next = (stat.n_left == 2'd2) ? grp_pkg::ST_WR1 : grp_pkg::ST_DONE;
      end
      grp_pkg::ST_WR1: begin
        cmd.wr_l1   = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_next  = grp_pkg::ST_DONE;
      end
      grp_pkg::ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = grp_pkg::ST_IDLE;
        end
      end
      default: state_next = grp_pkg::ST_INIT;
    endcase
  end

  `GRP_ASSERT_IMP(a_root_then_idle, cmd.load_root && state == grp_pkg::ST_INIT,
                  state_next == grp_pkg::ST_IDLE, "init does not reach idle")
  `GRP_ASSERT(a_one_write, !(cmd.wr_l0 && cmd.wr_l1), "two leftover writes at once")
  `GRP_ASSERT_IMP(a_no_overwrite, cmd.out_load, !stat.out_busy, "result word overwritten")

endmodule

// ----- hdl/guillotine_rect_packer_core.sv -----
// ---------------------------------------------------------------------------
// Guillotine rectangle packer core
// Keeps free space as a depth-first list of free rectangles in a 256-entry
// memory and places each rectangle in the first free one that it fits.
// ---------------------------------------------------------------------------
// A restart reloads the root rectangle. An insert scans to the first fit, then
// writes one leftover in place, shifts the later entries down to drop the used one,
// or shifts them up to make room for two leftovers. A full list refuses a fit that
// leaves two; a miss scans the whole list. One word is in flight at a time; the
// next input is taken the cycle after the result word is loaded.
// Synchronous reset; the root rectangle is written in the cycle before input opens.
module guillotine_rect_packer_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  grp_pkg::in_word_t           in_word,
  output logic                        out_valid,
  input  logic                        out_ready,
  output grp_pkg::out_word_t          out_word,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [grp_pkg::COORD_W-1:0] cfg_wdata
);

  grp_pkg::cmd_t  cmd;
  grp_pkg::stat_t stat;

  grp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  grp_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_word   (in_word),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule
